// ----- sv/pal_pkg.sv -----
package pal_pkg;

  localparam int DEPTH   = 128;
  localparam int GRP     = 16;
  localparam int NGRP    = (DEPTH + GRP - 1) / GRP;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > 8) ? CNT_W : 8;
  localparam int GIDX_W  = $clog2(GRP);
  localparam int GSEL_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int DATA_W  = 32;
  localparam int CMD_W   = 3;
  localparam int POS_W   = 8;
  localparam int STAT_W  = 3;
  localparam int FOUND_W = 7;
  localparam int FILL_W  = 8;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic              ld;
    logic              ins;
    logic              del;
    logic              srch;
    logic              rd;
    logic [CMP_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    logic [CMP_W-1:0]  count;
  } cell_ctl_t;

  typedef struct packed {
    logic              any;
    logic [GIDX_W-1:0] idx;
    logic [DATA_W-1:0] data;
  } grp_res_t;

endpackage

// ----- sv/pal_if.sv -----
interface pal_in_if;
  logic                             valid;
  logic                             ready;
  logic [pal_pkg::CMD_W-1:0]        cmd;
  logic [pal_pkg::POS_W-1:0]        position;
  logic signed [pal_pkg::DATA_W-1:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink (input valid, input cmd, input position, input value, output ready);
endinterface

interface pal_out_if;
  logic                              valid;
  logic                              ready;
  logic [pal_pkg::STAT_W-1:0]        status;
  logic [pal_pkg::FOUND_W-1:0]       found_position;
  logic signed [pal_pkg::DATA_W-1:0] data_out;
  logic [pal_pkg::FILL_W-1:0]        fill_level;

  modport source (output valid, output status, output found_position, output data_out,
                  output fill_level, input ready);
  modport sink (input valid, input status, input found_position, input data_out,
                input fill_level, output ready);
endinterface

// ----- sv/pal_cell.sv -----
module pal_cell (
  input  logic                         clk,
  input  pal_pkg::cell_ctl_t           ctl,
  input  logic [pal_pkg::CMP_W-1:0]    idx,
  input  logic [pal_pkg::DATA_W-1:0]   left,
  input  logic [pal_pkg::DATA_W-1:0]   right,
  output logic [pal_pkg::DATA_W-1:0]   entry,
  output logic                         hit
);

  logic [pal_pkg::DATA_W-1:0] entry_r, entry_nxt;
  logic                       hit_r, hit_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (idx == ctl.pos) begin
        entry_nxt = ctl.value;
      end else if (idx > ctl.pos) begin
        entry_nxt = left;
      end
    end else if (ctl.del && (idx >= ctl.pos)) begin
      entry_nxt = right;
    end
  end

  // hit: search match inside the list, or the addressed entry of a read
  always_comb begin
    hit_nxt = hit_r;
    if (ctl.ld) begin
      hit_nxt = (ctl.srch && (entry_r == ctl.value) && (idx < ctl.count)) ||
                (ctl.rd && (idx == ctl.pos));
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    hit_r   <= hit_nxt;
  end

  assign entry = entry_r;
  assign hit   = hit_r;

endmodule

// ----- sv/pal_group.sv -----
module pal_group (
  input  logic                        clk,
  input  logic [pal_pkg::GRP-1:0]     hits,
  input  logic [pal_pkg::DATA_W-1:0]  data [pal_pkg::GRP],
  output pal_pkg::grp_res_t           res
);

  pal_pkg::grp_res_t res_r, res_nxt;

  // first hit in the group, and the data of hit entries (one-hot on a read)
  always_comb begin
    res_nxt.any  = |hits;
    res_nxt.idx  = '0;
    res_nxt.data = '0;
    for (int k = pal_pkg::GRP - 1; k >= 0; k--) begin
      if (hits[k]) begin
        res_nxt.idx = pal_pkg::GIDX_W'(k);
      end
    end
    for (int k = 0; k < pal_pkg::GRP; k++) begin
      res_nxt.data = res_nxt.data | (data[k] & {pal_pkg::DATA_W{hits[k]}});
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

// ----- sv/positional_array_list.sv -----
// Ordered list of up to DEPTH signed 32-bit entries held in a chain of cells,
// one entry per cell. Insert and delete shift the affected cells toward their
// neighbors in the cycle of the transfer; every command then passes through
// registered steps before its result is offered: cells register their
// search or read hits, 16-cell groups register their first hit, and the
// groups are combined into the output register. A new input transfer is taken
// once the result sits in the output register, so no new command is taken
// while one is in flight; a stalled output holds the next command in
// its last step.
module positional_array_list (
  input  logic           clk,
  input  logic           rst_n,
  pal_in_if.sink         in_ch,
  pal_out_if.source      out_ch
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_PICK = 3'b100
  } state_t;

  state_t                              state_r, state_nxt;
  logic [pal_pkg::CNT_W-1:0]           count_r, count_nxt;
  logic                                is_srch_r, is_rd_r;
  logic [pal_pkg::STAT_W-1:0]          status_r, status_c;
  logic                                accept, ins_ok, del_ok, rd_ok;
  logic [pal_pkg::CMP_W-1:0]           pos_x, cnt_x;
  pal_pkg::cell_ctl_t                  ctl;

  logic [pal_pkg::DATA_W-1:0]          ent [pal_pkg::DEPTH];
  logic [pal_pkg::DEPTH-1:0]           hit_v;
  logic [pal_pkg::DATA_W-1:0]          ent_pad [pal_pkg::NGRP*pal_pkg::GRP];
  logic [pal_pkg::NGRP*pal_pkg::GRP-1:0] hit_pad;
  pal_pkg::grp_res_t                   grp [pal_pkg::NGRP];

  logic                                any_c;
  logic [pal_pkg::GSEL_W+pal_pkg::GIDX_W-1:0] fidx_c;
  logic [pal_pkg::DATA_W-1:0]          rdata_c;
  logic                                load;

  logic                                out_valid_r, out_valid_nxt;
  logic [pal_pkg::STAT_W-1:0]          out_status_r;
  logic [pal_pkg::FOUND_W-1:0]         out_found_r;
  logic [pal_pkg::DATA_W-1:0]          out_data_r;
  logic [pal_pkg::FILL_W-1:0]          out_fill_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign pos_x       = pal_pkg::CMP_W'(in_ch.position);
  assign cnt_x       = pal_pkg::CMP_W'(count_r);

  always_comb begin
    status_c = pal_pkg::ST_OK;
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    rd_ok    = 1'b0;
    case (in_ch.cmd)
      pal_pkg::CMD_INSERT: begin
        if (cnt_x >= pal_pkg::CMP_W'(pal_pkg::DEPTH)) begin
          status_c = pal_pkg::ST_FULL;
        end else if (pos_x > cnt_x) begin
          status_c = pal_pkg::ST_BADPOS;
        end else begin
          ins_ok = 1'b1;
        end
      end
      pal_pkg::CMD_DELETE: begin
        if (count_r == '0) begin
          status_c = pal_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status_c = pal_pkg::ST_BADPOS;
        end else begin
          del_ok = 1'b1;
        end
      end
      pal_pkg::CMD_READ: begin
        if (count_r == '0) begin
          status_c = pal_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status_c = pal_pkg::ST_BADPOS;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (ins_ok) begin
        count_nxt = count_r + 1'b1;
      end else if (del_ok) begin
        count_nxt = count_r - 1'b1;
      end else if (in_ch.cmd == pal_pkg::CMD_CLEAR) begin
        count_nxt = '0;
      end
    end
  end

  always_comb begin
    ctl.ld    = accept;
    ctl.ins   = accept && ins_ok;
    ctl.del   = accept && del_ok;
    ctl.srch  = (in_ch.cmd == pal_pkg::CMD_SEARCH);
    ctl.rd    = rd_ok;
    ctl.pos   = pos_x;
    ctl.value = in_ch.value;
    ctl.count = cnt_x;
  end

  // cell chain
  for (genvar i = 0; i < pal_pkg::DEPTH; i++) begin : g_cell
    logic [pal_pkg::DATA_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = ent[i-1];
    end
    if (i == pal_pkg::DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = ent[i+1];
    end
    pal_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   (pal_pkg::CMP_W'(i)),
      .left  (left_w),
      .right (right_w),
      .entry (ent[i]),
      .hit   (hit_v[i])
    );
  end

  for (genvar i = 0; i < pal_pkg::NGRP*pal_pkg::GRP; i++) begin : g_pad
    if (i < pal_pkg::DEPTH) begin : g_real
      assign ent_pad[i] = ent[i];
      assign hit_pad[i] = hit_v[i];
    end else begin : g_zero
      assign ent_pad[i] = '0;
      assign hit_pad[i] = 1'b0;
    end
  end

  for (genvar g = 0; g < pal_pkg::NGRP; g++) begin : g_grp
    logic [pal_pkg::DATA_W-1:0] gdat [pal_pkg::GRP];
    for (genvar k = 0; k < pal_pkg::GRP; k++) begin : g_dat
      assign gdat[k] = ent_pad[g*pal_pkg::GRP + k];
    end
    pal_group u_group (
      .clk  (clk),
      .hits (hit_pad[g*pal_pkg::GRP +: pal_pkg::GRP]),
      .data (gdat),
      .res  (grp[g])
    );
  end

  // lowest group with a hit wins
  always_comb begin
    any_c   = 1'b0;
    fidx_c  = '0;
    rdata_c = '0;
    for (int g = pal_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp[g].any) begin
        any_c  = 1'b1;
        fidx_c = {pal_pkg::GSEL_W'(g), grp[g].idx};
      end
      rdata_c = rdata_c | grp[g].data;
    end
  end

  assign load = (state_r == S_PICK) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_srch_r <= (in_ch.cmd == pal_pkg::CMD_SEARCH);
      is_rd_r   <= rd_ok;
      status_r  <= status_c;
    end
    if (load) begin
      if (is_srch_r) begin
        out_status_r <= any_c ? pal_pkg::ST_OK : pal_pkg::ST_NOTFOUND;
        out_found_r  <= any_c ? pal_pkg::FOUND_W'(fidx_c) : '0;
      end else begin
        out_status_r <= status_r;
        out_found_r  <= '0;
      end
      out_data_r <= is_rd_r ? rdata_c : '0;
      out_fill_r <= pal_pkg::FILL_W'(count_r);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.found_position = out_found_r;
  assign out_ch.data_out       = out_data_r;
  assign out_ch.fill_level     = out_fill_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pal_pkg::CNT_W'(pal_pkg::DEPTH))
    else $error("fill count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> count_r == pal_pkg::CNT_W'($past(count_r) + 1'b1))
    else $error("insert did not grow the list");

  a_read_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && is_rd_r |-> $onehot(hit_v))
    else $error("read hit not unique");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import pal_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int N_DIRECTED = 25;
  localparam int N_ITEMS    = 450;
  localparam int IDLE_LIMIT = 1000;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [FOUND_W-1:0]       found;
    logic signed [DATA_W-1:0] data;
    logic [FILL_W-1:0]        fill;
  } list_res_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    logic                     known;
    list_res_t                res;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_SPOTTY, RX_CHOKED} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic rx_ready = 1'b0;

  always #4 clk = ~clk;

  pal_in_if  in_ch();
  pal_out_if out_ch();

  assign out_ch.ready = rx_ready;

  positional_array_list dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the list
  logic signed [DATA_W-1:0] model_mem [DEPTH];
  int        model_len = 0;
  list_res_t list_replies [$];

  int       fault_count = 0;
  int       idle_cycles = 0;
  int       items_sent  = 0;
  int       burst_left  = 0;
  int       stall_left  = 0;
  int       stall_phase = 0;
  rx_mode_t stall_mode  = RX_OPEN;

  // Directed rows; entries with known set carry a hand-written expectation.
  dir_row_t dir_tab [N_DIRECTED] = '{
    '{CMD_READ,     8'd0,   32'sd0,        1'b1, '{ST_EMPTY,    7'd0, 32'sd0,        8'd0}},
    '{CMD_DELETE,   8'd0,   32'sd0,        1'b1, '{ST_EMPTY,    7'd0, 32'sd0,        8'd0}},
    '{CMD_SEARCH,   8'd0,   32'sd0,        1'b1, '{ST_NOTFOUND, 7'd0, 32'sd0,        8'd0}},
    '{CMD_INSERT,   8'd1,   32'sd5,        1'b1, '{ST_BADPOS,   7'd0, 32'sd0,        8'd0}},
    '{CMD_INSERT,   8'd0,   32'sh80000000, 1'b1, '{ST_OK,       7'd0, 32'sd0,        8'd1}},
    '{CMD_INSERT,   8'd1,   32'sh7fffffff, 1'b1, '{ST_OK,       7'd0, 32'sd0,        8'd2}},
    '{CMD_INSERT,   8'd255, 32'sd1,        1'b1, '{ST_BADPOS,   7'd0, 32'sd0,        8'd2}},
    '{CMD_INSERT,   8'd128, 32'sd1,        1'b1, '{ST_BADPOS,   7'd0, 32'sd0,        8'd2}},
    '{CMD_READ,     8'd0,   32'sd0,        1'b1, '{ST_OK,       7'd0, 32'sh80000000, 8'd2}},
    '{CMD_READ,     8'd1,   32'sd0,        1'b1, '{ST_OK,       7'd0, 32'sh7fffffff, 8'd2}},
    '{CMD_READ,     8'd2,   32'sd0,        1'b1, '{ST_BADPOS,   7'd0, 32'sd0,        8'd2}},
    '{CMD_READ,     8'd255, 32'sd0,        1'b1, '{ST_BADPOS,   7'd0, 32'sd0,        8'd2}},
    '{CMD_SEARCH,   8'd0,   32'sh7fffffff, 1'b1, '{ST_OK,       7'd1, 32'sd0,        8'd2}},
    '{CMD_SEARCH,   8'd0,   32'sd0,        1'b1, '{ST_NOTFOUND, 7'd0, 32'sd0,        8'd2}},
    '{CMD_INSERT,   8'd1,   -32'sd1,       1'b0, '0},
    '{CMD_INSERT,   8'd0,   32'sh7fffffff, 1'b0, '0},
    '{CMD_SEARCH,   8'd255, 32'sh7fffffff, 1'b0, '0},
    '{CMD_DELETE,   8'd4,   32'sd0,        1'b0, '0},
    '{CMD_DELETE,   8'd1,   32'sd0,        1'b0, '0},
    '{CMD_SPARE_LO, 8'd255, -32'sd1,       1'b0, '0},
    '{CMD_SPARE_HI, 8'd0,   32'sd0,        1'b0, '0},
    '{CMD_CLEAR,    8'd0,   32'sd0,        1'b1, '{ST_OK,       7'd0, 32'sd0,        8'd0}},
    '{CMD_SEARCH,   8'd0,   32'sh7fffffff, 1'b1, '{ST_NOTFOUND, 7'd0, 32'sd0,        8'd0}},
    '{CMD_READ,     8'd0,   32'sd0,        1'b1, '{ST_EMPTY,    7'd0, 32'sd0,        8'd0}},
    '{CMD_DELETE,   8'd255, 32'sd0,        1'b1, '{ST_EMPTY,    7'd0, 32'sd0,        8'd0}}
  };

  function automatic list_res_t list_apply(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                           logic signed [DATA_W-1:0] val);
    list_res_t r;
    int p;
    r = '0;
    p = int'(pos);
    case (cmd)
      CMD_INSERT: begin
        if (model_len >= DEPTH) begin
          r.status = ST_FULL;
        end else if (p > model_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = model_len; i > p; i--) model_mem[i] = model_mem[i-1];
          model_mem[p] = val;
          model_len++;
        end
      end
      CMD_DELETE: begin
        if (model_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= model_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = p; i + 1 < model_len; i++) model_mem[i] = model_mem[i+1];
          model_len--;
        end
      end
      CMD_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < model_len; i++) begin
          if (model_mem[i] == val) begin
            r.status = ST_OK;
            r.found  = FOUND_W'(i);
            break;
          end
        end
      end
      CMD_READ: begin
        if (model_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= model_len) begin
          r.status = ST_BADPOS;
        end else begin
          r.data = model_mem[p];
        end
      end
      CMD_CLEAR: model_len = 0;
      default: ;
    endcase
    r.fill = FILL_W'(model_len);
    return r;
  endfunction

  // Small values and extremes often, so searches hit duplicates.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return int'($urandom_range(0, 7)) - 4;
    if (r == 3) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    if (r == 4 && model_len > 0) return model_mem[$urandom_range(0, model_len - 1)];
    return $urandom();
  endfunction

  function automatic logic [POS_W-1:0] rand_pos(int hi);
    if (hi < 0 || $urandom_range(0, 7) == 0) return POS_W'($urandom());
    return POS_W'($urandom_range(0, hi));
  endfunction

  task automatic report(string msg);
    fault_count++;
    $display("%0t MISMATCH %s", $time, msg);
  endtask

  task automatic issue(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                       logic signed [DATA_W-1:0] val, logic known, list_res_t known_res);
    list_res_t pred;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.position <= pos;
    in_ch.value    <= val;
    do @(posedge clk); while (!in_ch.ready);
    pred = list_apply(cmd, pos, val);
    list_replies.push_back(known ? known_res : pred);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (list_replies.size() != 0);
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = rx_mode_t'($urandom_range(0, 2));
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    stall_phase = (stall_phase + 1) % 9;
    case (stall_mode)
      RX_OPEN:   rx_ready <= 1'b1;
      RX_SPOTTY: rx_ready <= ($urandom_range(0, 3) != 0);
      default:   rx_ready <= (stall_phase < 2);
    endcase
  end

  always @(posedge clk) begin
    list_res_t want;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (list_replies.size() == 0) begin
        report($sformatf("result with nothing pending, status %0d", out_ch.status));
      end else begin
        want = list_replies.pop_front();
        if (out_ch.status !== want.status)
          report($sformatf("status got %0d want %0d", out_ch.status, want.status));
        if (out_ch.found_position !== want.found)
          report($sformatf("found_position got %0d want %0d", out_ch.found_position,
                           want.found));
        if (out_ch.data_out !== want.data)
          report($sformatf("data_out got %0h want %0h", out_ch.data_out, want.data));
        if (out_ch.fill_level !== want.fill)
          report($sformatf("fill_level got %0d want %0d", out_ch.fill_level, want.fill));
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    list_res_t none;
    int unsigned pick;
    none = '0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= CMD_INSERT;
    in_ch.position <= '0;
    in_ch.value    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[k])
      issue(dir_tab[k].cmd, dir_tab[k].pos, dir_tab[k].val, dir_tab[k].known, dir_tab[k].res);
    wait_drained();

    // fill to capacity, probe the full list, then delete an entry and insert past capacity again
    issue(CMD_CLEAR, '0, '0, 1'b0, none);
    while (model_len < DEPTH)
      issue(CMD_INSERT, POS_W'($urandom_range(0, model_len)), pick_value(), 1'b0, none);
    issue(CMD_INSERT, POS_W'(DEPTH), pick_value(), 1'b0, none);
    issue(CMD_INSERT, '1, pick_value(), 1'b0, none);
    issue(CMD_READ, POS_W'(DEPTH - 1), '0, 1'b0, none);
    issue(CMD_READ, POS_W'(DEPTH), '0, 1'b0, none);
    issue(CMD_SEARCH, '0, model_mem[DEPTH - 1], 1'b0, none);
    issue(CMD_DELETE, '1, '0, 1'b0, none);
    issue(CMD_DELETE, POS_W'(DEPTH - 1), '0, 1'b0, none);
    issue(CMD_INSERT, '0, pick_value(), 1'b0, none);
    issue(CMD_INSERT, '0, pick_value(), 1'b0, none);
    wait_drained();

    while (items_sent < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 3)
        issue(CMD_CLEAR, POS_W'($urandom()), $urandom(), 1'b0, none);
      else if (pick < 40)
        issue(CMD_INSERT, rand_pos(model_len), pick_value(), 1'b0, none);
      else if (pick < 55)
        issue(CMD_DELETE, rand_pos(model_len - 1), pick_value(), 1'b0, none);
      else if (pick < 70)
        issue(CMD_SEARCH, POS_W'($urandom()), pick_value(), 1'b0, none);
      else if (pick < 88)
        issue(CMD_READ, rand_pos(model_len - 1), pick_value(), 1'b0, none);
      else
        issue(CMD_W'($urandom()), POS_W'($urandom()), $urandom(), 1'b0, none);
      if ($urandom_range(0, 63) == 0) wait_drained();
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
